// File: rtl/gcr_pkg.sv
// Shared constants, types and coefficient table of the gamma and contrast ramp.
`timescale 1ns / 1ps
`default_nettype none

package gcr_pkg;

  localparam int unsigned LOG_STEPS = 30;
  localparam int unsigned LOG_LAT   = LOG_STEPS + 2;
  localparam int unsigned EXP_STEPS = 20;
  localparam int unsigned EXP_LAT   = EXP_STEPS + 1;

  localparam logic [31:0] MANT_ONE   = 32'h8000_0000;
  localparam logic [31:0] EXP_MARGIN = 32'd8;

  localparam logic [15:0] REG_RESET = 16'd4096;
  localparam logic [15:0] LVL_MAX   = 16'hFFFF;

  localparam logic signed [35:0] LOG_B_UNIT = 36'sd21474836480;
  localparam logic signed [40:0] T_SAT      = 41'sd17179869184;
  localparam logic signed [26:0] B_HALF     = 27'sd524288;

  typedef logic [34:0] log_t;

  typedef enum logic [1:0] {
    SP_NONE = 2'd0,
    SP_ZERO = 2'd1,
    SP_FULL = 2'd2
  } sp_e;

  typedef enum logic [0:0] {
    REG_CONTRAST  = 1'b0,
    REG_INV_GAMMA = 1'b1
  } cfg_reg_e;

  // Q1.31 values of 2 raised to 2^-idx, rounded down.
  function automatic logic [31:0] exp_coef(input logic [4:0] idx);
    logic [31:0] c;
    unique case (idx)
      5'd1:    c = 32'd3037000499;
      5'd2:    c = 32'd2553802833;
      5'd3:    c = 32'd2341847523;
      5'd4:    c = 32'd2242560871;
      5'd5:    c = 32'd2194507416;
      5'd6:    c = 32'd2170868211;
      5'd7:    c = 32'd2159144271;
      5'd8:    c = 32'd2153306066;
      5'd9:    c = 32'd2150392886;
      5'd10:   c = 32'd2148937775;
      5'd11:   c = 32'd2148210588;
      5'd12:   c = 32'd2147847087;
      5'd13:   c = 32'd2147665360;
      5'd14:   c = 32'd2147574502;
      5'd15:   c = 32'd2147529074;
      5'd16:   c = 32'd2147506361;
      5'd17:   c = 32'd2147495004;
      5'd18:   c = 32'd2147489326;
      5'd19:   c = 32'd2147486487;
      5'd20:   c = 32'd2147485067;
      default: c = MANT_ONE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/gcr_log2.sv
// Pipelined base-2 logarithm in Q.30 by repeated squaring of the mantissa.
`timescale 1ns / 1ps
`default_nettype none

module gcr_log2 (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [31:0]   x_i,
  output logic               valid_o,
  output gcr_pkg::log_t      log_o
);
  import gcr_pkg::*;

  logic        v0_q, v1_q;
  logic [31:0] x0_q, m1_q;
  logic [4:0]  n0_q, n1_q, msb;

  logic        vs_q [LOG_STEPS];
  logic [31:0] m_q  [LOG_STEPS];
  logic [29:0] fr_q [LOG_STEPS];
  logic [4:0]  n_q  [LOG_STEPS];

  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (x_i[i]) begin
        msb = 5'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= x_i;
      n0_q <= msb;
      m1_q <= x0_q << (5'd31 - n0_q);
      n1_q <= n0_q;
    end
  end

  for (genvar s = 0; s < LOG_STEPS; s++) begin : g_step
    logic        v_in;
    logic [31:0] m_in;
    logic [29:0] f_in;
    logic [4:0]  n_in;
    logic [63:0] sq;

    if (s == 0) begin : g_first
      assign v_in = v1_q;
      assign m_in = m1_q;
      assign f_in = '0;
      assign n_in = n1_q;
    end else begin : g_next
      assign v_in = vs_q[s-1];
      assign m_in = m_q[s-1];
      assign f_in = fr_q[s-1];
      assign n_in = n_q[s-1];
    end

    assign sq = 64'(m_in) * 64'(m_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[s] <= 1'b0;
      end else if (en_i) begin
        vs_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[s]  <= sq[63] ? sq[63:32] : sq[62:31];
        fr_q[s] <= {f_in[28:0], sq[63]};
        n_q[s]  <= n_in;
      end
    end
  end

  assign valid_o = vs_q[LOG_STEPS-1];
  assign log_o   = {n_q[LOG_STEPS-1], fr_q[LOG_STEPS-1]};

  a_norm_mant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> m1_q[31])
    else $error("Normalized mantissa lost its leading one.");

endmodule

`default_nettype wire

// File: rtl/gcr_exp2.sv
// Pipelined power of two from a 4-bit exponent and a 20-bit fraction.
`timescale 1ns / 1ps
`default_nettype none

module gcr_exp2 (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [3:0]  n_i,
  input  wire logic [19:0] f_i,
  output logic             valid_o,
  output logic [15:0]      v_o
);
  import gcr_pkg::*;

  logic        vs_q [EXP_STEPS];
  logic [31:0] m_q  [EXP_STEPS];
  logic [19:0] f_q  [EXP_STEPS];
  logic [3:0]  n_q  [EXP_STEPS];
  logic        vo_q;
  logic [15:0] v_q;
  logic [31:0] shifted;

  for (genvar s = 0; s < EXP_STEPS; s++) begin : g_step
    localparam logic [31:0] Coef = exp_coef(5'(s + 1)) - EXP_MARGIN;
    logic        v_in;
    logic [31:0] m_in;
    logic [19:0] f_in;
    logic [3:0]  n_in;
    logic [63:0] prod;

    if (s == 0) begin : g_first
      assign v_in = valid_i;
      assign m_in = MANT_ONE;
      assign f_in = f_i;
      assign n_in = n_i;
    end else begin : g_next
      assign v_in = vs_q[s-1];
      assign m_in = m_q[s-1];
      assign f_in = f_q[s-1];
      assign n_in = n_q[s-1];
    end

    assign prod = 64'(m_in) * 64'(Coef);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[s] <= 1'b0;
      end else if (en_i) begin
        vs_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[s] <= f_in[EXP_STEPS-1-s] ? prod[62:31] : m_in;
        f_q[s] <= f_in;
        n_q[s] <= n_in;
      end
    end
  end

  assign shifted = m_q[EXP_STEPS-1] >> (5'd31 - 5'(n_q[EXP_STEPS-1]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_i) begin
      vo_q <= vs_q[EXP_STEPS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q <= shifted[15:0];
    end
  end

  assign valid_o = vo_q;
  assign v_o     = v_q;

  a_mant_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vs_q[EXP_STEPS-1] |-> m_q[EXP_STEPS-1][31])
    else $error("Power-of-two mantissa left its range.");

endmodule

`default_nettype wire

// File: rtl/gamma_contrast_ramp.sv
// Top level of the per-level contrast and gamma ramp.
//
// Usage: each transfer on the input channel (in_valid_i, in_stall_o, level_i)
// carries one 8-bit level, and each transfer on the output channel
// (out_valid_o, out_stall_i, ramp_value_o) returns its 16-bit ramp value in
// the same order. One level is taken every clock while in_stall_o is low.
// The level is scaled by contrast, its logarithm is formed by 30 squaring
// stages, scaled by the gamma reciprocal, turned back by a 20-stage power of
// two unit, and the result is checked against two neighbor candidates in two
// more logarithm pipelines; those three long pipelines set the latency.
// The configuration port (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i)
// is always ready; index 0 is contrast, index 1 the gamma reciprocal, both
// Q4.12; the user must write it only while no level is in flight (unenforced).
// Reset sets both registers to 1.0 and empties the pipeline.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall_o is raised in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module gamma_contrast_ramp (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  level_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      ramp_value_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import gcr_pkg::*;

  logic        en;
  logic [15:0] contrast_q, inv_gamma_q;

  logic               va_q;
  sp_e                sp_a_q, sp_a_d;
  logic [23:0]        b_a_q;
  logic signed [9:0]  lv_s;
  logic signed [26:0] b_s;

  logic        lb_valid;
  log_t        lb_log;
  sp_e         sp_l_q [LOG_LAT];

  logic               vc_q;
  sp_e                sp_c_q;
  logic signed [52:0] rhs_q;
  logic signed [35:0] lb_diff;

  logic               vd_q;
  sp_e                sp_d_q, sp_d_d;
  logic [33:0]        t_q;
  logic signed [40:0] t_s;

  logic        ve_valid;
  logic [15:0] v0;
  sp_e         sp_e_q [EXP_LAT];
  logic [33:0] t_e_q  [EXP_LAT];

  logic [16:0] cand1, cand2;
  logic        vr1_valid, vr2_valid;
  log_t        l1, l2;
  sp_e         sp_r_q [LOG_LAT];
  logic [33:0] t_r_q  [LOG_LAT];
  logic [15:0] v0_r_q [LOG_LAT];

  logic [16:0] fc1, fc2;
  logic        fit1, fit2;
  logic [15:0] result;
  logic        out_valid_q;
  logic [15:0] ramp_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contrast_q  <= REG_RESET;
      inv_gamma_q <= REG_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_CONTRAST:  contrast_q  <= cfg_data_i;
        REG_INV_GAMMA: inv_gamma_q <= cfg_data_i;
        default:       contrast_q  <= contrast_q;
      endcase
    end
  end

  assign lv_s = $signed({2'b00, level_i}) - 10'sd128;
  assign b_s  = 27'(lv_s) * 27'($signed({1'b0, contrast_q})) + B_HALF;

  always_comb begin
    if (inv_gamma_q == '0) begin
      sp_a_d = SP_FULL;
    end else if (b_s <= 27'sd0) begin
      sp_a_d = SP_ZERO;
    end else begin
      sp_a_d = SP_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i && !in_stall_o;
      vc_q <= lb_valid;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_a_q <= sp_a_d;
      b_a_q  <= b_s[23:0];
    end
  end

  gcr_log2 u_log_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (va_q),
    .x_i     ((sp_a_q == SP_NONE) ? {8'd0, b_a_q} : 32'd1),
    .valid_o (lb_valid),
    .log_o   (lb_log)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_l_q[0] <= sp_a_q;
      for (int i = 1; i < LOG_LAT; i++) begin
        sp_l_q[i] <= sp_l_q[i-1];
      end
    end
  end

  assign lb_diff = $signed({1'b0, lb_log}) - LOG_B_UNIT;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rhs_q  <= 53'(lb_diff) * 53'($signed({1'b0, inv_gamma_q}));
      sp_c_q <= sp_l_q[LOG_LAT-1];
    end
  end

  assign t_s = 41'(rhs_q >>> 12) + T_SAT;

  always_comb begin
    if (sp_c_q != SP_NONE) begin
      sp_d_d = sp_c_q;
    end else if (t_s < 41'sd0) begin
      sp_d_d = SP_ZERO;
    end else if (t_s >= T_SAT) begin
      sp_d_d = SP_FULL;
    end else begin
      sp_d_d = SP_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_d_q <= sp_d_d;
      t_q    <= t_s[33:0];
    end
  end

  gcr_exp2 u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vd_q),
    .n_i     (t_q[33:30]),
    .f_i     (t_q[29:10]),
    .valid_o (ve_valid),
    .v_o     (v0)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_e_q[0] <= sp_d_q;
      t_e_q[0]  <= t_q;
      for (int i = 1; i < EXP_LAT; i++) begin
        sp_e_q[i] <= sp_e_q[i-1];
        t_e_q[i]  <= t_e_q[i-1];
      end
    end
  end

  assign cand1 = {1'b0, v0} + 17'd1;
  assign cand2 = {1'b0, v0} + 17'd2;

  gcr_log2 u_log_c1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ve_valid),
    .x_i     ({15'd0, cand1}),
    .valid_o (vr1_valid),
    .log_o   (l1)
  );

  gcr_log2 u_log_c2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ve_valid),
    .x_i     ({15'd0, cand2}),
    .valid_o (vr2_valid),
    .log_o   (l2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sp_r_q[0] <= sp_e_q[EXP_LAT-1];
      t_r_q[0]  <= t_e_q[EXP_LAT-1];
      v0_r_q[0] <= v0;
      for (int i = 1; i < LOG_LAT; i++) begin
        sp_r_q[i] <= sp_r_q[i-1];
        t_r_q[i]  <= t_r_q[i-1];
        v0_r_q[i] <= v0_r_q[i-1];
      end
    end
  end

  assign fc1  = {1'b0, v0_r_q[LOG_LAT-1]} + 17'd1;
  assign fc2  = {1'b0, v0_r_q[LOG_LAT-1]} + 17'd2;
  assign fit1 = !fc1[16] && (l1 <= {1'b0, t_r_q[LOG_LAT-1]});
  assign fit2 = !fc2[16] && (l2 <= {1'b0, t_r_q[LOG_LAT-1]});

  always_comb begin
    priority if (sp_r_q[LOG_LAT-1] == SP_FULL) begin
      result = LVL_MAX;
    end else if (sp_r_q[LOG_LAT-1] == SP_ZERO) begin
      result = '0;
    end else if (fit2) begin
      result = fc2[15:0];
    end else if (fit1) begin
      result = fc1[15:0];
    end else begin
      result = v0_r_q[LOG_LAT-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vr1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ramp_q <= result;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ramp_value_o = ramp_q;

  a_cand_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vr1_valid && fit2 |-> fit1)
    else $error("Upper candidate fits while the lower one does not.");

  a_cand_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vr1_valid == vr2_valid)
    else $error("Candidate logarithm pipelines are out of step.");

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench of the contrast and gamma ramp with a scoreboard class.
`timescale 1ns / 1ps

module tb;
  import gcr_pkg::*;

  class ramp_scoreboard;
    logic [15:0] contrast;
    logic [15:0] inv_gamma;
    logic [15:0] pending[$];
    int errors;

    function new();
      contrast = REG_RESET;
      inv_gamma = REG_RESET;
      errors = 0;
    endfunction

    function longint log2_fix(longint unsigned x);
      int n;
      longint unsigned m;
      longint fr;
      n = 31;
      fr = 0;
      while (n > 0 && x[n] == 1'b0) n--;
      m = x << (31 - n);
      for (int i = 0; i < 30; i++) begin
        m = (m * m) >> 31;
        if (m >= 64'h1_0000_0000) begin
          fr = fr | (longint'(1) << (29 - i));
          m = m >> 1;
        end
      end
      return longint'(n) * 64'sd1073741824 + fr;
    endfunction

    function logic [15:0] ramp_of(logic [7:0] lvl);
      longint b;
      longint rhs;
      longint lhs;
      logic [15:0] v;
      logic [15:0] cand;
      b = (longint'(lvl) - 128) * longint'(contrast) + 524288;
      if (inv_gamma == 16'd0) return 16'hFFFF;
      if (b <= 0) return 16'd0;
      rhs = longint'(inv_gamma) * (log2_fix(b) - 20 * 64'sd1073741824);
      v = 16'd0;
      for (int bt = 15; bt >= 0; bt--) begin
        cand = v | (16'd1 << bt);
        lhs = (log2_fix(cand) - 16 * 64'sd1073741824) * 4096;
        if (lhs <= rhs) v = cand;
      end
      return v;
    endfunction

    function void note_level(logic [7:0] lvl);
      pending.push_back(ramp_of(lvl));
    endfunction

    function void check_ramp(logic [15:0] act);
      logic [15:0] exp_v;
      int diff;
      if (pending.size() == 0) begin
        $error("ramp_value arrived with nothing pending: actual %0d", act);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      diff = int'(act) - int'(exp_v);
      // The curve is allowed to be off by up to two counts.
      if (diff > 2 || diff < -2) begin
        $error("ramp_value mismatch: expected %0d actual %0d", exp_v, act);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [7:0] level = 8'd0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [0:0] cfg_index = 1'b0;
  logic [15:0] cfg_data = 16'd0;
  wire in_stall;
  wire out_valid;
  wire [15:0] ramp_value;
  wire cfg_ready;

  ramp_scoreboard sb = new();
  int rx_count = 0;
  bit rx_held = 1'b0;
  bit busy_mode = 1'b0;
  logic [7:0] corner_levels [7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};

  gamma_contrast_ramp dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .level_i(level),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .ramp_value_o(ramp_value),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always #2 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (busy_mode || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task write_reg(cfg_reg_e idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CONTRAST) sb.contrast = val;
    else sb.inv_gamma = val;
  endtask

  task send_level(logic [7:0] lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    level <= lvl;
    do @(posedge clk); while (in_stall);
    sb.note_level(lvl);
  endtask

  task drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task set_both(logic [15:0] c, logic [15:0] g);
    write_reg(REG_CONTRAST, c);
    write_reg(REG_INV_GAMMA, g);
  endtask

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_ramp(ramp_value);
        rx_count++;
      end
      if (rx_count >= 200 && !rx_held) begin
        rx_held = 1'b1;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (busy_mode) begin
        out_stall <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 3) hold = $urandom_range(20, 60);
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_levels[i]) send_level(corner_levels[i]);
    drain();
    set_both(16'd0, 16'd4096);
    send_level(8'd0);
    send_level(8'd255);
    drain();
    set_both(16'd4096, 16'd0);
    send_level(8'd10);
    send_level(8'd0);
    drain();
    set_both(16'hFFFF, 16'hFFFF);
    send_level(8'd0);
    send_level(8'd128);
    send_level(8'd255);
    drain();
    set_both(16'd8192, 16'd2048);
    send_level(8'd255);
    send_level(8'd0);
    send_level(8'd200);
    drain();
    set_both(16'd4096, 16'hFFFF);
    send_level(8'd1);
    send_level(8'd129);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: set_both(16'd4096, 16'd4096);
        1: set_both(16'hFFFF, 16'd1);
        2: set_both(16'd0, 16'hFFFF);
        3: set_both(16'd4096, 16'd9011);
        4: set_both(16'd2048, 16'd1862);
        default: set_both(16'($urandom_range(0, 65535)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(1024, 12288)));
      endcase
      busy_mode = (ph % 3 == 1);
      for (int k = 0; k < 100; k++) send_level(8'($urandom_range(0, 255)));
      drain();
    end
    busy_mode = 1'b0;

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
